// ===== design/swizzled_texel_address_assert.svh =====
// Assertion macros for the swizzled texel address block.
// Used by the checker; no other dependencies.
`ifndef SWIZZLED_TEXEL_ADDRESS_ASSERT_SVH
`define SWIZZLED_TEXEL_ADDRESS_ASSERT_SVH

// same-cycle implication
`define STXA_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("stxa assertion failed");

// next-cycle implication
`define STXA_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("stxa assertion failed");

`endif

// ===== design/stxa_pkg.sv =====
// Package for the swizzled texel address block: widths, register codes,
// block and column word tables. No dependencies.
package stxa_pkg;

   localparam int OUT_W      = 22;
   localparam int WIDTH_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int PAGE_SHIFT = 13;
   localparam int LOW_W      = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ADDRESS = 2'd0,
      CSR_BUFFER_WIDTH = 2'd1,
      CSR_PIXEL_FORMAT = 2'd2
   } csr_index_type;

   localparam logic [OUT_W-1:0]   BASE_RESET   = '0;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 6'd16;
   localparam logic               FORMAT_RESET = 1'b0;
   localparam logic               FORMAT_PSM4  = 1'b1;

   localparam logic [4:0] BLK8 [4][8] = '{
      '{5'd0,  5'd1,  5'd4,  5'd5,  5'd16, 5'd17, 5'd20, 5'd21},
      '{5'd2,  5'd3,  5'd6,  5'd7,  5'd18, 5'd19, 5'd22, 5'd23},
      '{5'd8,  5'd9,  5'd12, 5'd13, 5'd24, 5'd25, 5'd28, 5'd29},
      '{5'd10, 5'd11, 5'd14, 5'd15, 5'd26, 5'd27, 5'd30, 5'd31}
   };

   localparam logic [4:0] BLK4 [8][4] = '{
      '{5'd0,  5'd2,  5'd8,  5'd10},
      '{5'd1,  5'd3,  5'd9,  5'd11},
      '{5'd4,  5'd6,  5'd12, 5'd14},
      '{5'd5,  5'd7,  5'd13, 5'd15},
      '{5'd16, 5'd18, 5'd24, 5'd26},
      '{5'd17, 5'd19, 5'd25, 5'd27},
      '{5'd20, 5'd22, 5'd28, 5'd30},
      '{5'd21, 5'd23, 5'd29, 5'd31}
   };

   localparam logic [3:0] WORD_TAB [2][2][8] = '{
      '{'{4'd0, 4'd1, 4'd4, 4'd5, 4'd8, 4'd9, 4'd12, 4'd13},
        '{4'd2, 4'd3, 4'd6, 4'd7, 4'd10, 4'd11, 4'd14, 4'd15}},
      '{'{4'd8, 4'd9, 4'd12, 4'd13, 4'd0, 4'd1, 4'd4, 4'd5},
        '{4'd10, 4'd11, 4'd14, 4'd15, 4'd2, 4'd3, 4'd6, 4'd7}}
   };

endpackage

// ===== design/stxa_req_if.sv =====
// Request channel: texel coordinate with valid/ready handshake.
// No dependencies.
interface stxa_req_if #(
   parameter int COORD_BITS = 11
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] coord_x;
   logic [COORD_BITS-1:0] coord_y;

   modport source (output valid, coord_x, coord_y, input ready);
   modport sink   (input valid, coord_x, coord_y, output ready);
endinterface

// ===== design/stxa_rsp_if.sv =====
// Response channel: texel byte address and nibble select, valid/ready.
// Depends on stxa_pkg for the address width.
interface stxa_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [stxa_pkg::OUT_W-1:0] byte_address;
   logic                       high_nibble;

   modport source (output valid, byte_address, high_nibble, input ready);
   modport sink   (input valid, byte_address, high_nibble, output ready);
endinterface

// ===== design/swizzled_texel_address.sv =====
// Swizzled texel address generator, top level: three-stage pipeline.
// Depends on stxa_pkg, stxa_req_if and stxa_rsp_if.
//
//   port   | dir | carries
//   req    | in  | coord_x, coord_y
//   rsp    | out | byte_address, high_nibble
//   csr_*  | in  | base_address, buffer_width, pixel_format writes
//
// One transaction enters per cycle while req.ready is high.
// Stage 1 does the table lookups, stage 2 the row-by-width multiply,
// stage 3 the final address add into the output register.
// Reset clears the stage valid bits and loads the register defaults.
// A stall on rsp holds the full stages ahead of the first empty one;
// req.ready drops only while all three stages are full and rsp is stalled.
module swizzled_texel_address #(
   parameter int ADDR_BITS  = 22,
   parameter int COORD_BITS = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   stxa_req_if.sink                          req,
   stxa_rsp_if.source                        rsp,
   input  logic                              csr_write_enable,
   input  logic [stxa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stxa_pkg::OUT_W-1:0]        csr_write_data
);
   import stxa_pkg::*;

   localparam int RW   = COORD_BITS - 6;
   localparam int PW   = RW + WIDTH_W;
   localparam int XW   = COORD_BITS - 7;
   localparam int KEEP = (ADDR_BITS < OUT_W) ? ADDR_BITS : OUT_W;
   localparam logic [OUT_W-1:0] ADDR_MASK = OUT_W'((64'd1 << KEEP) - 64'd1);

   logic [OUT_W-1:0]   base_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic               format_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RESET;
         width_ff  <= WIDTH_RESET;
         format_ff <= FORMAT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_ff   <= csr_write_data;
            CSR_BUFFER_WIDTH: width_ff  <= csr_write_data[WIDTH_W-1:0];
            CSR_PIXEL_FORMAT: format_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   logic adv1, adv2, adv3;
   logic v1_ff, v2_ff, v3_ff;

   assign adv3      = !v3_ff || rsp.ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req.ready = adv1;

   // stage 1: lookups
   logic [COORD_BITS-1:0] x, y;
   logic [4:0]            block;
   logic [3:0]            word;
   logic [1:0]            lane;
   logic                  nib_in;
   logic [RW-1:0]         row_in;
   logic [LOW_W-1:0]      low_in;
   logic                  sub;

   assign x   = req.coord_x;
   assign y   = req.coord_y;
   assign sub = y[1] ^ y[2];

   always_comb begin
      word = WORD_TAB[sub][y[0]][x[2:0]];
      if (format_ff == FORMAT_PSM4) begin
         block  = BLK4[y[6:4]][x[6:5]];
         lane   = x[4:3];
         nib_in = y[1];
         row_in = RW'(y >> 7);
      end else begin
         block  = BLK8[y[5:4]][x[6:4]];
         lane   = {x[3], y[1]};
         nib_in = 1'b0;
         row_in = RW'(y >> 6);
      end
      low_in = {block, y[3:2], word, lane};
   end

   logic [RW-1:0]    row1_ff;
   logic [XW-1:0]    xpage1_ff, xpage2_ff;
   logic [LOW_W-1:0] low1_ff, low2_ff;
   logic             nib1_ff, nib2_ff;
   logic [PW-1:0]    prod_in, prod2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         row1_ff   <= row_in;
         xpage1_ff <= x[COORD_BITS-1:7];
         low1_ff   <= low_in;
         nib1_ff   <= nib_in;
      end
   end

   // stage 2: row times buffer width
   assign prod_in = PW'(row1_ff) * PW'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         prod2_ff  <= prod_in;
         xpage2_ff <= xpage1_ff;
         low2_ff   <= low1_ff;
         nib2_ff   <= nib1_ff;
      end
   end

   // stage 3: page and final address
   logic [PW-1:0]    page;
   logic [OUT_W-1:0] addr_in;
   logic [OUT_W-1:0] addr3_ff;
   logic             nib3_ff;

   always_comb begin
      page    = PW'(xpage2_ff) + (prod2_ff >> 1);
      addr_in = (base_ff + OUT_W'({page, {PAGE_SHIFT{1'b0}}}) + OUT_W'(low2_ff))
                & ADDR_MASK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         addr3_ff <= addr_in;
         nib3_ff  <= nib2_ff;
      end
   end

   assign rsp.valid        = v3_ff;
   assign rsp.byte_address = addr3_ff;
   assign rsp.high_nibble  = nib3_ff;

endmodule

// ===== design/stxa_checker.sv =====
// Port-level checker for swizzled_texel_address, bound to the top level.
// Depends on swizzled_texel_address_assert.svh.
`include "swizzled_texel_address_assert.svh"

module stxa_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   logic [1:0] pending_ff, pending_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `STXA_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `STXA_ASSERT_NOW(rsp_has_source, clock, reset, rsp_valid, pending_ff != 2'd0)
   `STXA_ASSERT_NOW(full_blocks_req, clock, reset, pending_ff == 2'd3 && !rsp_ready, !req_ready)
   `STXA_ASSERT_NEXT(reset_empties, clock, 1'b0, reset, !rsp_valid)

endmodule

bind swizzled_texel_address stxa_checker u_stxa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready)
);
